// ----- hw/rtl/eulerian_cycle_walker_macros.svh -----
// Assertion macros shared by the walker RTL. They compile away under synthesis.
`ifndef EULERIAN_CYCLE_WALKER_MACROS_SVH
`define EULERIAN_CYCLE_WALKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ECW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("eulerian_cycle_walker: assertion failed");

// Next-cycle implication, disabled during reset.
`define ECW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("eulerian_cycle_walker: assertion failed");

`else

`define ECW_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ECW_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- hw/rtl/ecw_pkg.sv -----
package ecw_pkg;

	localparam int NODE_W      = 8;
	localparam int MAX_NODES   = 256;
	localparam int MAX_EDGES   = 1024;
	localparam int EIDX_W      = 10;
	localparam int EPTR_W      = 11;
	localparam int STACK_DEPTH = MAX_EDGES + 1;
	localparam int SADDR_W     = 11;
	localparam int POS_W       = 11;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;

	// A list head equal to the edge capacity marks an empty list.
	localparam logic [EPTR_W-1:0] EDGE_EMPTY = EPTR_W'(MAX_EDGES);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_ADD_CHK,
		S_ADD_WR,
		S_RUN_INIT,
		S_RUN_HEAD,
		S_RUN_CHK,
		S_RUN_PUSH,
		S_RUN_POP,
		S_RD_CHK,
		S_RD_WAIT,
		S_DONE
	} state_t;

	// Control from the sequencer to the graph store.
	typedef struct packed {
		logic                clear;
		logic [NODE_W-1:0]   head_addr;
		logic                head_wr;
		logic [EPTR_W-1:0]   head_wdata;
		logic [EIDX_W-1:0]   edge_addr;
		logic                edge_wr;
		logic [NODE_W-1:0]   edge_tgt;
		logic [EPTR_W-1:0]   edge_prev;
	} graph_ctl_t;

	// Registered read data from the graph store.
	typedef struct packed {
		logic [EPTR_W-1:0]   head;
		logic [NODE_W-1:0]   tgt;
		logic [EPTR_W-1:0]   prev;
	} graph_rd_t;

endpackage

// ----- hw/rtl/ecw_req_if.sv -----
interface ecw_req_if;
	logic                            valid;
	logic                            ready;
	logic [ecw_pkg::CMD_W-1:0]       cmd;
	logic [ecw_pkg::NODE_W-1:0]      from_node;
	logic [ecw_pkg::NODE_W-1:0]      to_node;
	logic [ecw_pkg::POS_W-1:0]       position;

	modport source (output valid, cmd, from_node, to_node, position, input ready);
	modport sink (input valid, cmd, from_node, to_node, position, output ready);
endinterface

// ----- hw/rtl/ecw_rsp_if.sv -----
interface ecw_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ecw_pkg::NODE_W-1:0]      node_out;
	logic [ecw_pkg::SADDR_W-1:0]     cycle_length;
	logic [ecw_pkg::STATUS_W-1:0]    status;

	modport source (output valid, node_out, cycle_length, status, input ready);
	modport sink (input valid, node_out, cycle_length, status, output ready);
endinterface

// ----- hw/rtl/ecw_graph_store.sv -----
// Per-node list heads with valid bits, plus the edge store (target and link).
module ecw_graph_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ecw_pkg::graph_ctl_t    ctl,
	output ecw_pkg::graph_rd_t     rd
);

	logic [ecw_pkg::EPTR_W-1:0]    head_mem [ecw_pkg::MAX_NODES];
	logic [ecw_pkg::NODE_W-1:0]    tgt_mem  [ecw_pkg::MAX_EDGES];
	logic [ecw_pkg::EPTR_W-1:0]    prev_mem [ecw_pkg::MAX_EDGES];

	logic [ecw_pkg::MAX_NODES-1:0] head_vld_q;
	logic                          head_vld_rd_q;
	logic [ecw_pkg::EPTR_W-1:0]    head_raw_q;
	logic [ecw_pkg::NODE_W-1:0]    tgt_q;
	logic [ecw_pkg::EPTR_W-1:0]    prev_q;

	always_ff @(posedge clk) begin
		if (ctl.head_wr) begin
			head_mem[ctl.head_addr] <= ctl.head_wdata;
		end
		head_raw_q <= head_mem[ctl.head_addr];
		if (ctl.edge_wr) begin
			tgt_mem[ctl.edge_addr]  <= ctl.edge_tgt;
			prev_mem[ctl.edge_addr] <= ctl.edge_prev;
		end
		tgt_q  <= tgt_mem[ctl.edge_addr];
		prev_q <= prev_mem[ctl.edge_addr];
	end

	// A head that was never written since the last clear reads as an empty list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_vld_rd_q <= 1'b0;
		end else begin
			head_vld_rd_q <= head_vld_q[ctl.head_addr];
			if (ctl.clear) begin
				head_vld_q <= '0;
			end else if (ctl.head_wr) begin
				head_vld_q[ctl.head_addr] <= 1'b1;
			end
		end
	end

	assign rd.head = head_vld_rd_q ? head_raw_q : ecw_pkg::EDGE_EMPTY;
	assign rd.tgt  = tgt_q;
	assign rd.prev = prev_q;

endmodule

// ----- hw/rtl/ecw_node_ram.sv -----
// Single-write, single-read node memory with registered read data.
module ecw_node_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [ecw_pkg::SADDR_W-1:0] wr_addr,
	input  logic [ecw_pkg::NODE_W-1:0]  wr_data,
	input  logic [ecw_pkg::SADDR_W-1:0] rd_addr,
	output logic [ecw_pkg::NODE_W-1:0]  rd_data
);

	logic [ecw_pkg::NODE_W-1:0] mem [ecw_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hw/rtl/eulerian_cycle_walker.sv -----
// Eulerian cycle walker. Requests carry one of four commands. Clear empties every
// adjacency list at once (valid bits, no sweep). Add edge pushes an edge onto the
// front of its source node's list, or reports status 1 when all MAX_EDGES edge slots
// are in use; slots come back only on a clear. Run performs Hierholzer's stack
// walk from node 0, always following the most recently added unused edge, and
// records each node as it is popped; every push is a registered read of the head
// and edge memory followed by a write. Read returns the node at a position of the
// last cycle in forward order, or status 2 when the position is at or past the
// cycle length. Every response carries the cycle length after the command. One
// request is worked on at a time; a new request may be taken while the previous
// response still waits.
`include "eulerian_cycle_walker_macros.svh"

module eulerian_cycle_walker (
	input  logic       clk,
	input  logic       arst_n,
	ecw_req_if.sink    req,
	ecw_rsp_if.source  rsp
);

	ecw_pkg::state_t                  state_q, state_d;
	logic [ecw_pkg::EPTR_W-1:0]       edge_count_q, edge_count_d;
	logic [ecw_pkg::SADDR_W-1:0]      cycle_count_q, cycle_count_d;
	logic [ecw_pkg::SADDR_W-1:0]      sp_q, sp_d;
	logic [ecw_pkg::SADDR_W-1:0]      n_q, n_d;
	logic [ecw_pkg::NODE_W-1:0]       cur_q, cur_d;

	// Latched request fields.
	logic [ecw_pkg::NODE_W-1:0]       from_q;
	logic [ecw_pkg::NODE_W-1:0]       to_q;
	logic [ecw_pkg::POS_W-1:0]        pos_q;

	// Result under construction.
	logic [ecw_pkg::NODE_W-1:0]       node_q, node_d;
	ecw_pkg::status_t                 status_q, status_d;

	// Output register.
	logic                             rsp_vld_q;
	logic [ecw_pkg::NODE_W-1:0]       rsp_node_q;
	logic [ecw_pkg::SADDR_W-1:0]      rsp_len_q;
	logic [ecw_pkg::STATUS_W-1:0]     rsp_status_q;
	logic                             rsp_load;

	logic                             req_accept;

	ecw_pkg::graph_ctl_t              gctl;
	ecw_pkg::graph_rd_t               grd;

	logic                             stk_wr;
	logic [ecw_pkg::SADDR_W-1:0]      stk_waddr;
	logic [ecw_pkg::NODE_W-1:0]       stk_wdata;
	logic [ecw_pkg::SADDR_W-1:0]      stk_raddr;
	logic [ecw_pkg::NODE_W-1:0]       stk_rdata;

	logic                             cyc_wr;
	logic [ecw_pkg::SADDR_W-1:0]      cyc_raddr;
	logic [ecw_pkg::NODE_W-1:0]       cyc_rdata;

	ecw_graph_store u_graph (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gctl),
		.rd     (grd)
	);

	// Walk stack. The node on top is also held in cur_q, so the memory is only
	// read back when a pop exposes the node below.
	ecw_node_ram u_walk_stack (
		.clk     (clk),
		.wr_en   (stk_wr),
		.wr_addr (stk_waddr),
		.wr_data (stk_wdata),
		.rd_addr (stk_raddr),
		.rd_data (stk_rdata)
	);

	// Cycle store, filled in pop order and read back from the far end.
	ecw_node_ram u_cycle_store (
		.clk     (clk),
		.wr_en   (cyc_wr),
		.wr_addr (n_q),
		.wr_data (cur_q),
		.rd_addr (cyc_raddr),
		.rd_data (cyc_rdata)
	);

	assign req.ready  = (state_q == ecw_pkg::S_IDLE);
	assign req_accept = req.valid && req.ready;

	always_comb begin
		state_d       = state_q;
		edge_count_d  = edge_count_q;
		cycle_count_d = cycle_count_q;
		sp_d          = sp_q;
		n_d           = n_q;
		cur_d         = cur_q;
		node_d        = node_q;
		status_d      = status_q;

		gctl            = '0;
		gctl.head_addr  = cur_q;
		gctl.edge_addr  = grd.head[ecw_pkg::EIDX_W-1:0];

		stk_wr    = 1'b0;
		stk_waddr = sp_q;
		stk_wdata = grd.tgt;
		stk_raddr = sp_q - ecw_pkg::SADDR_W'(2);

		cyc_wr    = 1'b0;
		cyc_raddr = cycle_count_q - ecw_pkg::SADDR_W'(1) - pos_q;

		rsp_load = 1'b0;

		unique case (state_q)
			ecw_pkg::S_IDLE: begin
				if (req.valid) begin
					node_d   = '0;
					status_d = ecw_pkg::ST_OK;
					unique case (ecw_pkg::cmd_t'(req.cmd))
						ecw_pkg::CMD_CLEAR: state_d = ecw_pkg::S_CLEAR;
						ecw_pkg::CMD_ADD:   state_d = ecw_pkg::S_ADD_CHK;
						ecw_pkg::CMD_RUN:   state_d = ecw_pkg::S_RUN_INIT;
						ecw_pkg::CMD_READ:  state_d = ecw_pkg::S_RD_CHK;
						default:            state_d = ecw_pkg::S_IDLE;
					endcase
				end
			end
			ecw_pkg::S_CLEAR: begin
				gctl.clear   = 1'b1;
				edge_count_d = '0;
				state_d      = ecw_pkg::S_DONE;
			end
			ecw_pkg::S_ADD_CHK: begin
				gctl.head_addr = from_q;
				if (edge_count_q == ecw_pkg::EDGE_EMPTY) begin
					status_d = ecw_pkg::ST_FULL;
					state_d  = ecw_pkg::S_DONE;
				end else begin
					state_d = ecw_pkg::S_ADD_WR;
				end
			end
			ecw_pkg::S_ADD_WR: begin
				// The new edge links to the old head and becomes the head.
				gctl.head_addr  = from_q;
				gctl.head_wr    = 1'b1;
				gctl.head_wdata = edge_count_q;
				gctl.edge_addr  = edge_count_q[ecw_pkg::EIDX_W-1:0];
				gctl.edge_wr    = 1'b1;
				gctl.edge_tgt   = to_q;
				gctl.edge_prev  = grd.head;
				edge_count_d    = edge_count_q + ecw_pkg::EPTR_W'(1);
				state_d         = ecw_pkg::S_DONE;
			end
			ecw_pkg::S_RUN_INIT: begin
				sp_d      = ecw_pkg::SADDR_W'(1);
				n_d       = '0;
				cur_d     = '0;
				stk_wr    = 1'b1;
				stk_waddr = '0;
				stk_wdata = '0;
				state_d   = ecw_pkg::S_RUN_HEAD;
			end
			ecw_pkg::S_RUN_HEAD: begin
				state_d = ecw_pkg::S_RUN_CHK;
			end
			ecw_pkg::S_RUN_CHK: begin
				if ((grd.head < ecw_pkg::EDGE_EMPTY) &&
				    (sp_q < ecw_pkg::SADDR_W'(ecw_pkg::STACK_DEPTH))) begin
					state_d = ecw_pkg::S_RUN_PUSH;
				end else begin
					// No unused edge left, or the stack is full: the top node goes into the cycle.
					if (n_q < ecw_pkg::SADDR_W'(ecw_pkg::STACK_DEPTH)) begin
						cyc_wr = 1'b1;
						n_d    = n_q + ecw_pkg::SADDR_W'(1);
					end
					sp_d = sp_q - ecw_pkg::SADDR_W'(1);
					if (sp_q == ecw_pkg::SADDR_W'(1)) begin
						cycle_count_d = n_d;
						state_d       = ecw_pkg::S_DONE;
					end else begin
						state_d = ecw_pkg::S_RUN_POP;
					end
				end
			end
			ecw_pkg::S_RUN_PUSH: begin
				// Consume the edge and step to its target.
				gctl.head_wr    = 1'b1;
				gctl.head_wdata = grd.prev;
				stk_wr          = 1'b1;
				sp_d            = sp_q + ecw_pkg::SADDR_W'(1);
				cur_d           = grd.tgt;
				state_d         = ecw_pkg::S_RUN_HEAD;
			end
			ecw_pkg::S_RUN_POP: begin
				cur_d   = stk_rdata;
				state_d = ecw_pkg::S_RUN_HEAD;
			end
			ecw_pkg::S_RD_CHK: begin
				if (pos_q < cycle_count_q) begin
					state_d = ecw_pkg::S_RD_WAIT;
				end else begin
					status_d = ecw_pkg::ST_RANGE;
					state_d  = ecw_pkg::S_DONE;
				end
			end
			ecw_pkg::S_RD_WAIT: begin
				node_d  = cyc_rdata;
				state_d = ecw_pkg::S_DONE;
			end
			ecw_pkg::S_DONE: begin
				if (!rsp_vld_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ecw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ecw_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ecw_pkg::S_IDLE;
			edge_count_q  <= '0;
			cycle_count_q <= '0;
			sp_q          <= '0;
			n_q           <= '0;
			rsp_vld_q     <= 1'b0;
		end else begin
			state_q       <= state_d;
			edge_count_q  <= edge_count_d;
			cycle_count_q <= cycle_count_d;
			sp_q          <= sp_d;
			n_q           <= n_d;
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		node_q   <= node_d;
		status_q <= status_d;
		if (req_accept) begin
			from_q <= req.from_node;
			to_q   <= req.to_node;
			pos_q  <= req.position;
		end
		if (rsp_load) begin
			rsp_node_q   <= node_q;
			rsp_len_q    <= cycle_count_q;
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.node_out     = rsp_node_q;
	assign rsp.cycle_length = rsp_len_q;
	assign rsp.status       = rsp_status_q;

	// The walk never runs with an empty stack.
	`ECW_ASSERT_IMP(a_walk_sp_live, clk, arst_n, (state_q == ecw_pkg::S_RUN_HEAD) || (state_q == ecw_pkg::S_RUN_CHK) || (state_q == ecw_pkg::S_RUN_PUSH) || (state_q == ecw_pkg::S_RUN_POP), (sp_q != '0))
	// Popped plus stacked nodes never outgrow the stores.
	`ECW_ASSERT_IMP(a_walk_depth, clk, arst_n, (state_q == ecw_pkg::S_RUN_HEAD) || (state_q == ecw_pkg::S_RUN_CHK), ((ecw_pkg::SADDR_W+1)'(n_q) + (ecw_pkg::SADDR_W+1)'(sp_q) <= (ecw_pkg::SADDR_W+1)'(ecw_pkg::STACK_DEPTH)))
	// An accepted request always starts work.
	`ECW_ASSERT_NXT(a_accept_starts, clk, arst_n, req_accept, (state_q != ecw_pkg::S_IDLE))
	// A new response appears only when a command has finished.
	`ECW_ASSERT_IMP(a_rsp_from_done, clk, arst_n, $rose(rsp_vld_q), ($past(state_q) == ecw_pkg::S_DONE))

endmodule
